>>> hdl/assert_macros.svh
// Assertion macros used by two_edge_flood_reachability.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Implication checked at every rising edge, disabled while in reset.
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

>>> hdl/tefr_pkg.sv
// ----------------------------------------------------------------------------
// tefr_pkg
// Shared constants and types for the two_edge_flood_reachability block.
// ----------------------------------------------------------------------------
package tefr_pkg;
    localparam int MaxDim     = 8;
    localparam int HeightBits = 16;
    localparam int Cells      = MaxDim * MaxDim;
    localparam int IdxBits    = $clog2(Cells);
    localparam int DimBits    = $clog2(MaxDim);

    typedef logic [IdxBits-1:0]    t_idx;
    typedef logic [DimBits-1:0]    t_dim;
    typedef logic [HeightBits-1:0] t_height;

    // Register indexes of the configuration port.
    localparam logic [3:0] RegNumRows = 4'd0;
    localparam logic [3:0] RegNumCols = 4'd1;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_LOAD,
        S_CLEAR,
        S_SEED,
        S_SEED_RD,
        S_POP,
        S_POP_RD,
        S_NBR,
        S_NBR_RD,
        S_EMIT
    } t_state;

    // Clamp a size register to 1..MaxDim, minus one.
    function automatic t_dim clamp_dim(input logic [3:0] v);
        logic [4:0] w;
        begin
            w = {1'b0, v};
            if (w == 5'd0) begin
                clamp_dim = '0;
            end else if (w > 5'(MaxDim)) begin
                clamp_dim = t_dim'(MaxDim - 1);
            end else begin
                clamp_dim = t_dim'(w - 5'd1);
            end
        end
    endfunction
endpackage

>>> hdl/tefr_ram.sv
// ----------------------------------------------------------------------------
// tefr_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module tefr_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // One write and one read per cycle; a read during a write returns the old word.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> hdl/two_edge_flood_reachability.sv
// ----------------------------------------------------------------------------
// two_edge_flood_reachability
// Loads a height grid, runs two stack-based flood fills and lists the cells
// reached from both edge pairs.
// ----------------------------------------------------------------------------
// Channel   Direction  Signals
// command   in         i_start, o_busy, i_height
// config    in         i_cfg_we, i_cfg_index, i_cfg_data
// result    out        o_valid, o_row, o_col, o_found, o_last
//
// Cells load at one per cycle with busy low. The final cell starts a job:
// the reach maps are cleared in full, then each fill checks its edge seeds
// and walks from every unmarked one: it pops a cell, tests its four
// neighbours and pushes each one it reaches, until the stack is empty. The
// scan then reads one cell per cycle in row-major order; busy stays high
// until the final result shows.
// Reset is synchronous. The receiver cannot stall: each result shows for
// one cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module two_edge_flood_reachability import tefr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [15:0] i_height,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data,
    output logic        o_valid,
    output logic [2:0]  o_row,
    output logic [2:0]  o_col,
    output logic        o_found,
    output logic        o_last
);
    t_state r_state, n_state;
    logic [3:0] r_rows_reg, r_cols_reg;
    logic [IdxBits:0] r_load, n_load;
    logic [IdxBits:0] r_cnt, n_cnt;       // clear, seed and scan counter
    logic r_fill, n_fill;                 // 0 first fill, 1 second
    logic [IdxBits:0] r_sp, n_sp;
    t_dim r_cr, n_cr, r_cc, n_cc;         // current cell, or scan position
    t_height r_ch, n_ch;                  // current height
    logic [1:0] r_dir, n_dir;
    t_dim r_nr, n_nr, r_nc, n_nc;         // neighbour under test
    logic r_ov, n_ov, r_of, n_of, r_ol, n_ol;
    logic [2:0] r_orow, n_orow, r_ocol, n_ocol;
    logic r_pv, n_pv, r_pend, n_pend;     // scan read in flight, final one
    t_dim r_pr, n_pr, r_pc, n_pc;         // position of the scan read
    logic r_hv, n_hv;                     // a hit is held back
    t_dim r_hr, n_hr, r_hc, n_hc;
    logic r_flush, n_flush;

    t_dim rm, cm;
    logic [3:0] rows, cols;
    assign rm = clamp_dim(r_rows_reg);
    assign cm = clamp_dim(r_cols_reg);
    assign rows = 4'(rm) + 4'd1;
    assign cols = 4'(cm) + 4'd1;

    logic accept;
    assign accept = i_start && !o_busy;

    // Height RAM, stack RAM and the two reach map RAMs.
    logic h_we, s_we;
    t_idx h_addr, s_addr;
    t_height h_rd;
    logic [2*DimBits-1:0] s_rd, s_wd;
    logic m0_we, m1_we, m_wd, m0_rd, m1_rd, map_rd;
    t_idx m_addr;
    tefr_ram #(.Width(HeightBits), .Depth(Cells)) u_hram (
        .i_clk(i_clk), .i_we(h_we), .i_addr(h_addr), .i_wdata(i_height), .o_rdata(h_rd));
    tefr_ram #(.Width(2*DimBits), .Depth(Cells)) u_sram (
        .i_clk(i_clk), .i_we(s_we), .i_addr(s_addr), .i_wdata(s_wd), .o_rdata(s_rd));
    tefr_ram #(.Width(1), .Depth(Cells)) u_map0 (
        .i_clk(i_clk), .i_we(m0_we), .i_addr(m_addr), .i_wdata(m_wd), .o_rdata(m0_rd));
    tefr_ram #(.Width(1), .Depth(Cells)) u_map1 (
        .i_clk(i_clk), .i_we(m1_we), .i_addr(m_addr), .i_wdata(m_wd), .o_rdata(m1_rd));
    assign map_rd = r_fill ? m1_rd : m0_rd;

    // Cell index from row and column.
    function automatic t_idx lin(input t_dim r, input t_dim c, input logic [3:0] nc);
        begin
            lin = t_idx'(t_idx'(r) * t_idx'(nc) + t_idx'(c));
        end
    endfunction

    // Seed cell for the current seed count.
    t_dim sd_r, sd_c;
    logic [IdxBits:0] nseeds;
    logic [IdxBits:0] seed_k;
    assign nseeds = (IdxBits+1)'(rows) + (IdxBits+1)'(cols);
    assign seed_k = r_cnt;
    always_comb begin
        if (seed_k < (IdxBits+1)'(rows)) begin
            sd_r = t_dim'(seed_k);
            sd_c = r_fill ? cm : '0;
        end else begin
            sd_c = t_dim'(seed_k - (IdxBits+1)'(rows));
            sd_r = r_fill ? rm : '0;
        end
    end
    t_idx sd_idx, nb_idx, cur_idx;
    assign sd_idx  = lin(sd_r, sd_c, cols);
    assign nb_idx  = lin(r_nr, r_nc, cols);
    assign cur_idx = lin(r_cr, r_cc, cols);

    // Neighbour position for a direction; valid flag.
    logic nb_ok;
    t_dim nb_r, nb_c;
    always_comb begin
        nb_ok = 1'b1;
        nb_r = r_cr;
        nb_c = r_cc;
        case (r_dir)
            2'd0: begin
                if (r_cc == cm) nb_ok = 1'b0;
                nb_c = r_cc + t_dim'(1);
            end
            2'd1: begin
                if (r_cr == rm) nb_ok = 1'b0;
                nb_r = r_cr + t_dim'(1);
            end
            2'd2: begin
                if (r_cc == '0) nb_ok = 1'b0;
                nb_c = r_cc - t_dim'(1);
            end
            default: begin
                if (r_cr == '0) nb_ok = 1'b0;
                nb_r = r_cr - t_dim'(1);
            end
        endcase
    end

    // The neighbour is pushed when it is in the grid, unmarked and not lower.
    logic push_nb;
    assign push_nb = nb_ok && !map_rd && !(r_ch > h_rd);

    logic [IdxBits:0] total;
    assign total = (IdxBits+1)'(rows * cols);

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD:    if (accept && (r_load + 1'b1 >= total)) n_state = S_CLEAR;
            S_CLEAR:   if (r_cnt == (IdxBits+1)'(Cells - 1)) n_state = S_SEED;
            S_SEED: begin
                if (r_cnt == nseeds) n_state = r_fill ? S_EMIT : S_SEED;
                else n_state = S_SEED_RD;
            end
            S_SEED_RD: n_state = map_rd ? S_SEED : S_POP;
            S_POP:     n_state = (r_sp == '0) ? S_SEED : S_POP_RD;
            S_POP_RD:  n_state = S_NBR;
            S_NBR:     n_state = S_NBR_RD;
            S_NBR_RD:  n_state = (r_dir == 2'd3 || !nb_ok) && (r_dir == 2'd3) ? S_POP : S_NBR;
            S_EMIT:    if (r_cnt + 1'b1 >= total) n_state = S_LOAD;
            default:   n_state = S_LOAD;
        endcase
    end

    // Datapath and outputs of the sequencer.
    always_comb begin
        n_load = r_load; n_cnt = r_cnt; n_fill = r_fill; n_sp = r_sp;
        n_cr = r_cr; n_cc = r_cc; n_ch = r_ch; n_dir = r_dir;
        n_nr = r_nr; n_nc = r_nc;
        h_we = 1'b0; h_addr = r_load[IdxBits-1:0];
        s_we = 1'b0; s_addr = r_sp[IdxBits-1:0]; s_wd = {sd_r, sd_c};
        m0_we = 1'b0; m1_we = 1'b0; m_addr = r_cnt[IdxBits-1:0]; m_wd = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                if (accept) begin
                    h_we = 1'b1;
                    if (r_load + 1'b1 >= total) begin
                        n_load = '0;
                        n_cnt = '0;
                    end else begin
                        n_load = r_load + 1'b1;
                    end
                end
            end
            S_CLEAR: begin
                m0_we = 1'b1; m1_we = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == (IdxBits+1)'(Cells - 1)) begin
                    n_cnt = '0; n_fill = 1'b0; n_sp = '0;
                end
            end
            S_SEED: begin
                m_addr = sd_idx;
                if (r_cnt == nseeds) begin
                    n_cnt = '0;
                    n_fill = 1'b1;
                    n_cr = '0; n_cc = '0;
                end
            end
            S_SEED_RD: begin
                // The seed is pushed and marked when its mark reads clear.
                m_addr = sd_idx;
                n_cnt = r_cnt + 1'b1;
                if (!map_rd) begin
                    s_we = 1'b1; s_addr = '0; s_wd = {sd_r, sd_c};
                    n_sp = (IdxBits+1)'(1);
                    m_wd = 1'b1; m0_we = !r_fill; m1_we = r_fill;
                end
            end
            S_POP: begin
                s_addr = t_idx'(r_sp - 1'b1);
                if (r_sp != '0) n_sp = r_sp - 1'b1;
            end
            S_POP_RD: begin
                n_cr = s_rd[2*DimBits-1:DimBits];
                n_cc = s_rd[DimBits-1:0];
                h_addr = lin(s_rd[2*DimBits-1:DimBits], s_rd[DimBits-1:0], cols);
                n_dir = 2'd0;
            end
            S_NBR: begin
                if (r_dir == 2'd0) n_ch = h_rd;
                n_nr = nb_r; n_nc = nb_c;
                h_addr = lin(nb_r, nb_c, cols);
                m_addr = lin(nb_r, nb_c, cols);
            end
            S_NBR_RD: begin
                m_addr = nb_idx;
                if (push_nb) begin
                    s_we = 1'b1; s_addr = r_sp[IdxBits-1:0]; s_wd = {r_nr, r_nc};
                    n_sp = r_sp + 1'b1;
                    m_wd = 1'b1; m0_we = !r_fill; m1_we = r_fill;
                end
                n_dir = r_dir + 2'd1;
                h_addr = cur_idx;
            end
            S_EMIT: begin
                // Scan in row-major order; both maps are read at the count.
                n_cnt = r_cnt + 1'b1;
                if (r_cc == cm) begin
                    n_cc = '0;
                    n_cr = r_cr + t_dim'(1);
                end else begin
                    n_cc = r_cc + t_dim'(1);
                end
            end
            default: ;
        endcase
        // A size write starts a new grid.
        if (i_cfg_we && (i_cfg_index == RegNumRows || i_cfg_index == RegNumCols)) begin
            n_load = '0;
        end
    end

    // Output stage: a hit is held until the next hit or the end of the scan,
    // so the final one can carry last; an empty scan gives one empty answer.
    always_comb begin
        n_pv   = (r_state == S_EMIT);
        n_pend = (r_state == S_EMIT) && (r_cnt + 1'b1 >= total);
        n_pr   = r_cr;
        n_pc   = r_cc;
        n_ov = 1'b0; n_of = r_of; n_ol = r_ol; n_orow = r_orow; n_ocol = r_ocol;
        n_hv = r_hv; n_hr = r_hr; n_hc = r_hc;
        n_flush = 1'b0;
        if (r_pv) begin
            if (m0_rd && m1_rd) begin
                if (r_hv) begin
                    n_ov = 1'b1; n_of = 1'b1; n_ol = 1'b0;
                    n_orow = r_hr; n_ocol = r_hc;
                end
                n_hv = 1'b1; n_hr = r_pr; n_hc = r_pc;
            end
            n_flush = r_pend;
        end
        if (r_flush) begin
            n_ov = 1'b1; n_of = r_hv; n_ol = 1'b1;
            n_orow = r_hv ? r_hr : '0;
            n_ocol = r_hv ? r_hc : '0;
            n_hv = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_rows_reg <= 4'd8; r_cols_reg <= 4'd8;
            r_load <= '0; r_cnt <= '0; r_fill <= 1'b0; r_sp <= '0;
            r_ov <= 1'b0; r_pv <= 1'b0; r_flush <= 1'b0; r_hv <= 1'b0;
        end else begin
            r_state <= n_state;
            r_load <= n_load; r_cnt <= n_cnt; r_fill <= n_fill; r_sp <= n_sp;
            r_ov <= n_ov; r_pv <= n_pv; r_flush <= n_flush; r_hv <= n_hv;
            if (i_cfg_we) begin
                if (i_cfg_index == RegNumRows) begin
                    r_rows_reg <= i_cfg_data;
                end else if (i_cfg_index == RegNumCols) begin
                    r_cols_reg <= i_cfg_data;
                end
            end
        end
        r_cr <= n_cr; r_cc <= n_cc; r_ch <= n_ch; r_dir <= n_dir;
        r_nr <= n_nr; r_nc <= n_nc;
        r_of <= n_of; r_ol <= n_ol; r_orow <= n_orow; r_ocol <= n_ocol;
        r_pend <= n_pend; r_pr <= n_pr; r_pc <= n_pc;
        r_hr <= n_hr; r_hc <= n_hc;
    end

    assign o_busy  = (r_state != S_LOAD) || r_pv || r_flush;
    assign o_valid = r_ov;
    assign o_row   = r_orow;
    assign o_col   = r_ocol;
    assign o_found = r_of;
    assign o_last  = r_ol;

    `ASSERT_IMPL(a_no_start_busy, i_clk, i_rst_n, o_valid && !o_found, o_last)
    `ASSERT_NEXT(a_clear_after_load, i_clk, i_rst_n,
        r_state == S_LOAD && n_state == S_CLEAR, r_state == S_CLEAR)
    `ASSERT_IMPL(a_sp_bound, i_clk, i_rst_n, 1'b1, r_sp <= (IdxBits+1)'(Cells))
endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for two_edge_flood_reachability. Height grids of many
// sizes are loaded through the command port, a local model floods both edge
// pairs and the listed cells are compared field by field with the block.
// ----------------------------------------------------------------------------
module tb;
    import tefr_pkg::*;

    localparam int WatchLimit = 20000;
    localparam int DrainWait  = 16;
    localparam int ItemGoal   = 430;

    typedef struct packed {
        logic [2:0] row;
        logic [2:0] col;
        logic       found;
        logic       last;
    } t_cell_out;

    typedef enum logic [1:0] {
        OP_ROWS,
        OP_COLS,
        OP_CELL
    } t_dir_op;

    typedef struct {
        t_dir_op    op;
        logic [15:0] val;
        bit         typed;
        t_cell_out  want;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic [15:0] i_height;
    logic        i_cfg_we;
    logic [3:0]  i_cfg_index;
    logic [3:0]  i_cfg_data;
    logic        o_valid;
    logic [2:0]  o_row;
    logic [2:0]  o_col;
    logic        o_found;
    logic        o_last;

    // Local copy of the block state.
    logic [3:0]  grid_rows_reg;
    logic [3:0]  grid_cols_reg;
    t_height     cell_heights [Cells];
    bit          reach_tl [Cells];
    bit          reach_br [Cells];
    int          cells_loaded;

    t_cell_out   pending_cells [$];
    int          mismatches = 0;
    int          items_sent;
    int          idle_cycles = 0;

    two_edge_flood_reachability dut (.*);

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int clamp_size(logic [3:0] v);
        if (v == 4'd0) return 1;
        if (v > 4'(MaxDim)) return MaxDim;
        return int'(v);
    endfunction

    // Stack-based fill from one seed into the selected reach map.
    function automatic void flood_from(bit second, int rows, int cols, int r0, int c0);
        int  stack [$];
        int  cur;
        int  nr;
        int  nc;
        int  nxt;
        int  dr [4];
        int  dc [4];
        dr = '{0, 1, 0, -1};
        dc = '{1, 0, -1, 0};
        cur = r0 * cols + c0;
        if (second ? reach_br[cur] : reach_tl[cur]) return;
        if (second) reach_br[cur] = 1; else reach_tl[cur] = 1;
        stack.insert(stack.size(), cur);
        while (stack.size() > 0) begin
            cur = stack.pop_back();
            for (int d = 0; d < 4; d++) begin
                nr = cur / cols + dr[d];
                nc = cur % cols + dc[d];
                if (nr < 0 || nr >= rows || nc < 0 || nc >= cols) continue;
                nxt = nr * cols + nc;
                if (second ? reach_br[nxt] : reach_tl[nxt]) continue;
                if (cell_heights[cur] > cell_heights[nxt]) continue;
                if (second) reach_br[nxt] = 1; else reach_tl[nxt] = 1;
                stack.insert(stack.size(), nxt);
            end
        end
    endfunction

    // Store one cell; on the last cell of a grid, list the cells both fills reach.
    function automatic void model_cell(t_height h, ref t_cell_out found_cells [$]);
        int rows;
        int cols;
        t_cell_out c;
        rows = clamp_size(grid_rows_reg);
        cols = clamp_size(grid_cols_reg);
        found_cells.delete();
        if (cells_loaded < Cells) cell_heights[cells_loaded] = h;
        cells_loaded++;
        if (cells_loaded < rows * cols) return;
        cells_loaded = 0;
        foreach (reach_tl[k]) begin
            reach_tl[k] = 0;
            reach_br[k] = 0;
        end
        for (int i = 0; i < rows; i++) begin
            flood_from(0, rows, cols, i, 0);
            flood_from(1, rows, cols, i, cols - 1);
        end
        for (int i = 0; i < cols; i++) begin
            flood_from(0, rows, cols, 0, i);
            flood_from(1, rows, cols, rows - 1, i);
        end
        for (int r = 0; r < rows; r++) begin
            for (int k = 0; k < cols; k++) begin
                if (reach_tl[r * cols + k] && reach_br[r * cols + k]) begin
                    c.row = 3'(r);
                    c.col = 3'(k);
                    c.found = 1'b1;
                    c.last = 1'b0;
                    found_cells.insert(found_cells.size(), c);
                end
            end
        end
        if (found_cells.size() == 0) begin
            c = '0;
            c.last = 1'b1;
            found_cells.insert(found_cells.size(), c);
        end else begin
            found_cells[found_cells.size() - 1].last = 1'b1;
        end
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_cell(t_height h, bit typed, t_cell_out want);
        t_cell_out found_cells [$];
        i_start  <= 1'b1;
        i_height <= h;
        do @(posedge i_clk); while (o_busy);
        model_cell(h, found_cells);
        if (typed && found_cells.size() > 0) begin
            found_cells.delete();
            found_cells.insert(found_cells.size(), want);
        end
        foreach (found_cells[k]) pending_cells.insert(pending_cells.size(), found_cells[k]);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Wait at a falling edge with start low until the block has gone quiet.
    task automatic wait_quiet();
        i_start <= 1'b0;
        do @(negedge i_clk); while (pending_cells.size() != 0 || o_busy);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [3:0] idx, logic [3:0] val);
        i_start     <= 1'b0;
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == RegNumRows) grid_rows_reg = val; else grid_cols_reg = val;
        cells_loaded = 0;
    endtask

    task automatic sender_gap();
        if ($urandom_range(0, 3) == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
    endtask

    function automatic logic [3:0] pick_size();
        case ($urandom_range(0, 11))
            0: return 4'd0;
            1: return 4'($urandom_range(9, 15));
            2, 3: return 4'd8;
            4: return 4'($urandom_range(5, 7));
            default: return 4'($urandom_range(1, 4));
        endcase
    endfunction

    function automatic t_height pick_height(int style);
        case (style)
            0: return t_height'($urandom);
            1: return t_height'($urandom_range(0, 3));
            default: return $urandom_range(0, 1) ? 16'hffff : 16'h0000;
        endcase
    endfunction

    // Result checker and watchdog.
    always @(posedge i_clk) begin
        t_cell_out want;
        if (i_rst_n) begin
            if ((i_start && !o_busy) || o_valid) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WatchLimit) begin
                $display("simulation failed");
                $finish;
            end
            if (o_valid) begin
                if (pending_cells.size() == 0) begin
                    report_mismatch("result count", 1, 0);
                end else begin
                    want = pending_cells.pop_front();
                    if (o_row !== want.row) report_mismatch("row", o_row, want.row);
                    if (o_col !== want.col) report_mismatch("col", o_col, want.col);
                    if (o_found !== want.found) report_mismatch("found", o_found, want.found);
                    if (o_last !== want.last) report_mismatch("last", o_last, want.last);
                end
            end
        end
    end

    // Stimulus: directed rows first, then random grids.
    initial begin
        t_dir_row  dir_rows [23];
        t_cell_out none;
        int        style;
        int        grid_cells;
        none = '0;
        dir_rows = '{
            '{OP_ROWS, 16'd0, 0, none},
            '{OP_COLS, 16'd0, 0, none},
            '{OP_CELL, 16'hffff, 1, '{3'd0, 3'd0, 1'b1, 1'b1}},
            '{OP_ROWS, 16'd1, 0, none},
            '{OP_COLS, 16'd15, 0, none},
            '{OP_CELL, 16'h0000, 0, none},
            '{OP_CELL, 16'hffff, 0, none},
            '{OP_CELL, 16'h0001, 0, none},
            '{OP_CELL, 16'h8000, 0, none},
            '{OP_CELL, 16'h7fff, 0, none},
            '{OP_CELL, 16'h0000, 0, none},
            '{OP_CELL, 16'hffff, 0, none},
            '{OP_CELL, 16'h1234, 0, none},
            '{OP_ROWS, 16'd2, 0, none},
            '{OP_COLS, 16'd2, 0, none},
            '{OP_CELL, 16'h0000, 0, none},
            '{OP_CELL, 16'hffff, 0, none},
            '{OP_ROWS, 16'd9, 0, none},
            '{OP_ROWS, 16'd2, 0, none},
            '{OP_CELL, 16'hffff, 0, none},
            '{OP_CELL, 16'h0000, 0, none},
            '{OP_CELL, 16'h0000, 0, none},
            '{OP_CELL, 16'hffff, 0, none}
        };
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_height = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        items_sent = 0;
        grid_rows_reg = 4'd8;
        grid_cols_reg = 4'd8;
        cells_loaded = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[k]) begin
            if (dir_rows[k].op == OP_CELL) begin
                send_cell(dir_rows[k].val, dir_rows[k].typed, dir_rows[k].want);
            end else begin
                wait_quiet();
                write_reg(dir_rows[k].op == OP_ROWS ? RegNumRows : RegNumCols,
                          dir_rows[k].val[3:0]);
            end
        end

        // Random grids, sometimes broken off partway by a size write.
        while (items_sent < ItemGoal) begin
            wait_quiet();
            if ($urandom_range(0, 1)) begin
                write_reg(RegNumRows, pick_size());
                write_reg(RegNumCols, pick_size());
            end else begin
                write_reg(RegNumCols, pick_size());
                write_reg(RegNumRows, pick_size());
            end
            style = $urandom_range(0, 2);
            grid_cells = clamp_size(grid_rows_reg) * clamp_size(grid_cols_reg);
            if ($urandom_range(0, 7) == 0 && grid_cells > 1) begin
                repeat ($urandom_range(1, grid_cells - 1)) begin
                    send_cell(pick_height(style), 0, none);
                    sender_gap();
                end
                wait_quiet();
                write_reg(RegNumRows, grid_rows_reg);
            end
            repeat (grid_cells) begin
                send_cell(pick_height(style), 0, none);
                if ($urandom_range(0, 2) != 0) sender_gap();
            end
        end

        i_start <= 1'b0;
        do @(posedge i_clk); while (pending_cells.size() != 0);
        repeat (DrainWait) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
